/* design/rmq_pkg.sv */
// Package for the range min/max query table.
// Holds the widths, op codes, the slot entry type and the sequencer states.
// No dependencies.
package rmq_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int PRICE_W   = 32;
    localparam int TAG_W     = 16;
    localparam int OP_W      = 2;

    // Op codes of the input transaction; the fourth code is ignored
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [TAG_W-1:0]   tag_t;

    // Highest and lowest priced entry of a slot (or of a running fold)
    typedef struct packed {
        price_t top_price;
        tag_t   top_tag;
        price_t bot_price;
        tag_t   bot_tag;
    } rmq_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_FOLD,
        ST_Q_SCAN,
        ST_Q_DONE
    } rmq_state_t;

endpackage

/* design/rmq_fold_unit.sv */
// Shared max/min fold unit of the range min/max query table.
// Merges a candidate entry into an accumulated entry; used for adds and queries.
// Depends on rmq_pkg.
module rmq_fold_unit (
    input  rmq_pkg::rmq_entry_t acc,
    input  logic                acc_valid,
    input  rmq_pkg::rmq_entry_t cand,
    input  logic                cand_valid,
    output rmq_pkg::rmq_entry_t res,
    output logic                res_valid
);
    import rmq_pkg::*;

    // Strict compares: on a tie the accumulated (earlier) entry is kept
    always_comb begin
        res       = acc;
        res_valid = acc_valid | cand_valid;
        if (cand_valid) begin
            if (!acc_valid) begin
                res = cand;
            end else begin
                if (cand.top_price > acc.top_price) begin
                    res.top_price = cand.top_price;
                    res.top_tag   = cand.top_tag;
                end
                if (cand.bot_price < acc.bot_price) begin
                    res.bot_price = cand.bot_price;
                    res.bot_tag   = cand.bot_tag;
                end
            end
        end
    end

endmodule

/* design/range_min_max_query_table.sv */
// Range min/max query table, top level.
// Slot store, fill bits, scan sequencer and output register; uses rmq_pkg and rmq_fold_unit.
//
// Usage:
//   Input channel s_*: one transaction carries op, slot, price, entry_tag, range_lo
//   and range_hi. An add folds (price, entry_tag) into its slot, keeping the
//   highest and lowest priced entry. A clear empties all slots at once. A query
//   returns one m_* transaction with the highest and lowest priced entries over
//   the filled slots from range_lo to range_hi; found is 0 (other fields 0) when
//   the range is inverted or holds no filled slot. The unused op code is dropped.
//   Timing: s_ready is high only while the sequencer is idle. An add reads the
//   store, then folds and writes back; a clear completes at acceptance. A query
//   walks the slot store one slot per cycle through the shared fold unit from
//   range_lo to range_hi and then registers the result; an inverted range skips
//   the scan. The single read port of the slot store sets that pace.
//   The result sits in an output register, so adds and clears are taken while
//   it waits; a further query finishes its scan and then holds until m_ready
//   frees the register.
//   Reset (aresetn low, synchronous) empties all slots and drops any pending
//   result; no clearing pass is needed.
module range_min_max_query_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rmq_pkg::OP_W-1:0]      s_op,
    input  logic [rmq_pkg::SLOT_W-1:0]    s_slot,
    input  logic [rmq_pkg::PRICE_W-1:0]   s_price,
    input  logic [rmq_pkg::TAG_W-1:0]     s_entry_tag,
    input  logic [rmq_pkg::SLOT_W-1:0]    s_range_lo,
    input  logic [rmq_pkg::SLOT_W-1:0]    s_range_hi,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [rmq_pkg::PRICE_W-1:0]   m_max_price,
    output logic [rmq_pkg::TAG_W-1:0]     m_max_tag,
    output logic [rmq_pkg::PRICE_W-1:0]   m_min_price,
    output logic [rmq_pkg::TAG_W-1:0]     m_min_tag
);
    import rmq_pkg::*;

    rmq_state_t             state_reg, state_next;
    logic [NUM_SLOTS-1:0]   filled_reg, filled_next;
    slot_idx_t              idx_reg, idx_next;
    slot_idx_t              hi_reg, hi_next;
    price_t                 price_reg, price_next;
    tag_t                   tag_reg, tag_next;
    rmq_entry_t             acc_reg, acc_next;
    logic                   acc_valid_reg, acc_valid_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg, m_found_next;
    rmq_entry_t             m_res_reg, m_res_next;

    rmq_entry_t             mem [NUM_SLOTS];
    rmq_entry_t             rd_data_reg;
    slot_idx_t              rd_addr;

    rmq_entry_t             fold_acc, fold_cand, fold_res;
    logic                   fold_acc_valid, fold_cand_valid, fold_res_valid;

    logic                   s_xact;
    logic                   out_free;

    assign s_xact   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Slot store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADD_FOLD) begin
            mem[idx_reg] <= fold_res;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Read address: slot or range start at acceptance, next slot while scanning
    always_comb begin
        case (state_reg)
            ST_IDLE:   rd_addr = (s_op == OP_ADD) ? s_slot : s_range_lo;
            ST_Q_SCAN: rd_addr = idx_reg + slot_idx_t'(1);
            default:   rd_addr = idx_reg;
        endcase
    end

    // Fold unit operands: stored slot against new entry, or running result against slot
    always_comb begin
        if (state_reg == ST_ADD_FOLD) begin
            fold_acc        = rd_data_reg;
            fold_acc_valid  = filled_reg[idx_reg];
            fold_cand       = '{top_price: price_reg, top_tag: tag_reg,
                                bot_price: price_reg, bot_tag: tag_reg};
            fold_cand_valid = 1'b1;
        end else begin
            fold_acc        = acc_reg;
            fold_acc_valid  = acc_valid_reg;
            fold_cand       = rd_data_reg;
            fold_cand_valid = filled_reg[idx_reg];
        end
    end

    rmq_fold_unit u_fold (
        .acc        (fold_acc),
        .acc_valid  (fold_acc_valid),
        .cand       (fold_cand),
        .cand_valid (fold_cand_valid),
        .res        (fold_res),
        .res_valid  (fold_res_valid)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xact) begin
                    if (s_op == OP_ADD) begin
                        state_next = ST_ADD_FOLD;
                    end else if (s_op == OP_QUERY) begin
                        state_next = (s_range_lo > s_range_hi) ? ST_Q_DONE : ST_Q_SCAN;
                    end
                end
            end
            ST_ADD_FOLD: state_next = ST_IDLE;
            ST_Q_SCAN: begin
                if (idx_reg == hi_reg) begin
                    state_next = ST_Q_DONE;
                end
            end
            ST_Q_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output updates
    always_comb begin
        filled_next    = filled_reg;
        idx_next       = idx_reg;
        hi_next        = hi_reg;
        price_next     = price_reg;
        tag_next       = tag_reg;
        acc_next       = acc_reg;
        acc_valid_next = acc_valid_reg;
        m_found_next   = m_found_reg;
        m_res_next     = m_res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_xact) begin
                    price_next     = s_price;
                    tag_next       = s_entry_tag;
                    hi_next        = s_range_hi;
                    acc_next       = '0;
                    acc_valid_next = 1'b0;
                    idx_next       = (s_op == OP_ADD) ? s_slot : s_range_lo;
                    if (s_op == OP_CLEAR) begin
                        filled_next = '0;
                    end
                end
            end
            ST_ADD_FOLD: begin
                filled_next[idx_reg] = 1'b1;
            end
            ST_Q_SCAN: begin
                acc_next       = fold_res;
                acc_valid_next = fold_res_valid;
                idx_next       = idx_reg + slot_idx_t'(1);
            end
            ST_Q_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = acc_valid_reg;
                    m_res_next   = acc_valid_reg ? acc_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            m_valid_reg   <= 1'b0;
            acc_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            m_valid_reg   <= m_valid_next;
            acc_valid_reg <= acc_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        hi_reg      <= hi_next;
        price_reg   <= price_next;
        tag_reg     <= tag_next;
        acc_reg     <= acc_next;
        m_found_reg <= m_found_next;
        m_res_reg   <= m_res_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_max_price = m_res_reg.top_price;
    assign m_max_tag   = m_res_reg.top_tag;
    assign m_min_price = m_res_reg.bot_price;
    assign m_min_tag   = m_res_reg.bot_tag;

    // An empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_res_reg == '0))
        else $error("empty query result has non-zero fields");

    // A found result never has its minimum above its maximum
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> (m_res_reg.bot_price <= m_res_reg.top_price))
        else $error("query minimum above maximum");

    // A clear empties every slot on the next cycle
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xact && s_op == OP_CLEAR) |=> (filled_reg == '0))
        else $error("clear left a filled slot");

    // The scan pointer never passes the end of the requested range
    a_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_SCAN) |-> (idx_reg <= hi_reg))
        else $error("scan pointer past end of range");

    // An add leaves its slot filled
    a_add_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD_FOLD) |=> filled_reg[$past(idx_reg)])
        else $error("add did not mark slot filled");

endmodule
